// File: rtl/psup_pkg.sv
// Shared types and constants for the positioning move supervisor.
`timescale 1ns / 1ps
`default_nettype none

package psup_pkg;

  localparam int COORD_BITS  = 32;
  localparam int THR_BITS    = 16;
  localparam int OVR_BITS    = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [THR_BITS-1:0] THR_RESET = 16'd10;
  localparam logic [OVR_BITS-1:0] OVR_RESET = 24'd100;

  // Settle window: one reference sample and two more.
  localparam logic [1:0] SETTLE_LAST = 2'd2;
  // Stop request seen with drive on more polls than this count plus one is an error.
  localparam logic [1:0] STOP_IGN_MAX = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STILL_THR = 1'b0,
    CFG_OVERRUN   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_MOVING = 2'd2,
    PH_SETTLE = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_MOVING        = 4'd0,
    ST_SETTLING      = 4'd1,
    ST_OK            = 4'd2,
    ST_NO_MOTION     = 4'd3,
    ST_WRONG_DIR     = 4'd4,
    ST_DRIVE_DROPPED = 4'd5,
    ST_STOP_IGNORED  = 4'd6,
    ST_LIMIT         = 4'd7,
    ST_OVERRUN       = 4'd8,
    ST_DRIFT         = 4'd9,
    ST_IDLE          = 4'd10
  } status_t;

  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] target_position;
    logic                         move_direction;
    logic signed [COORD_BITS-1:0] position;
    logic                         stop_request;
    logic                         driving_right;
    logic                         driving_left;
    logic                         limit_right;
    logic                         limit_left;
    logic                         blocked;
  } in_item_t;

  typedef struct packed {
    status_t status;
    logic    finished;
  } out_item_t;

  typedef struct packed {
    logic [THR_BITS-1:0] still_threshold;
    logic [OVR_BITS-1:0] overrun_limit;
  } cfg_t;

  typedef struct packed {
    phase_t                       phase;
    logic signed [COORD_BITS-1:0] target_code;
    logic                         dir_decreasing;
    logic signed [COORD_BITS-1:0] previous_position;
    logic signed [COORD_BITS-1:0] reference_position;
    logic [1:0]                   stop_ignored_count;
    logic [1:0]                   settle_count;
    status_t                      last_status;
  } sup_state_t;

endpackage

`default_nettype wire

// File: rtl/psup_eval.sv
// Per-item check logic: next supervisor state and the result for one item.
`timescale 1ns / 1ps
`default_nettype none

module psup_eval (
  input  psup_pkg::in_item_t   item,
  input  psup_pkg::sup_state_t cur,
  input  psup_pkg::cfg_t       cfg,
  output psup_pkg::sup_state_t nxt,
  output psup_pkg::out_item_t  res
);
  import psup_pkg::*;

  localparam int DW = COORD_BITS + 2;

  logic signed [DW-1:0] pos_x;
  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] diff_abs;
  logic signed [DW-1:0] dev;
  logic signed [DW-1:0] dev_abs;
  logic signed [DW-1:0] to_go;
  logic signed [DW-1:0] thr_x;
  logic signed [DW-1:0] lim_x;
  logic                 stop;
  logic                 drv;
  logic                 lim;
  logic                 no_motion;
  logic                 wrong_dir;
  logic                 overrun;
  logic                 drift;

  always_comb begin
    pos_x    = DW'(item.position);
    diff     = pos_x - DW'(cur.previous_position);
    diff_abs = diff[DW-1] ? -diff : diff;
    dev      = pos_x - DW'(cur.reference_position);
    dev_abs  = dev[DW-1] ? -dev : dev;
    to_go    = DW'(cur.target_code) - pos_x;
    thr_x    = DW'($unsigned(cfg.still_threshold));
    lim_x    = DW'($unsigned(cfg.overrun_limit));
    stop     = item.stop_request;
    drv      = item.driving_right | item.driving_left;
    lim      = item.limit_right | item.limit_left | item.blocked;
    no_motion = (diff_abs <= thr_x);
    wrong_dir = diff[DW-1] != cur.dir_decreasing;
    // Only travel past the target on the commanded side counts.
    overrun  = ((to_go < -lim_x) && !cur.dir_decreasing) ||
               ((to_go > lim_x) && cur.dir_decreasing);
    drift    = (dev_abs > thr_x);
  end

  always_comb begin
    nxt          = cur;
    res.status   = cur.last_status;
    res.finished = 1'b0;
    if (item.kind == KIND_START) begin
      nxt.target_code        = item.target_position;
      nxt.dir_decreasing     = item.move_direction;
      nxt.stop_ignored_count = 2'd0;
      nxt.settle_count       = 2'd0;
      nxt.phase              = PH_FIRST;
      nxt.last_status        = ST_MOVING;
      res.status             = ST_MOVING;
    end else begin
      case (cur.phase)
        PH_FIRST, PH_MOVING: begin
          if (stop && !drv) begin
            nxt.phase        = PH_SETTLE;
            nxt.settle_count = 2'd0;
            nxt.last_status  = ST_SETTLING;
            res.status       = ST_SETTLING;
          end else if (cur.phase == PH_MOVING && no_motion) begin
            res.status = ST_NO_MOTION;
          end else if (cur.phase == PH_MOVING && wrong_dir) begin
            res.status = ST_WRONG_DIR;
          end else if (!stop && !drv) begin
            res.status = ST_DRIVE_DROPPED;
          end else if (stop && cur.stop_ignored_count > STOP_IGN_MAX) begin
            res.status = ST_STOP_IGNORED;
          end else begin
            if (stop) begin
              nxt.stop_ignored_count = cur.stop_ignored_count + 2'd1;
            end
            if (lim) begin
              res.status = ST_LIMIT;
            end else if (overrun) begin
              res.status = ST_OVERRUN;
            end else begin
              nxt.previous_position = item.position;
              nxt.phase             = PH_MOVING;
              nxt.last_status       = ST_MOVING;
              res.status            = ST_MOVING;
            end
          end
          res.finished = (res.status != ST_MOVING) && (res.status != ST_SETTLING);
        end
        PH_SETTLE: begin
          if (cur.settle_count == 2'd0) begin
            nxt.reference_position = item.position;
            nxt.settle_count       = 2'd1;
            res.status             = ST_SETTLING;
          end else if (drift) begin
            res.status = ST_DRIFT;
          end else if (cur.settle_count >= SETTLE_LAST) begin
            res.status = ST_OK;
          end else begin
            nxt.settle_count = cur.settle_count + 2'd1;
            res.status       = ST_SETTLING;
          end
          res.finished = (res.status != ST_SETTLING);
        end
        default: begin
          res.status   = cur.last_status;
          res.finished = (cur.last_status != ST_IDLE);
        end
      endcase
      // Any finishing result ends the move.
      if (res.finished && cur.phase != PH_IDLE) begin
        nxt.phase       = PH_IDLE;
        nxt.last_status = res.status;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/positioning_move_supervisor_top.sv
// Top level of the positioning move supervisor: registers, handshake, config.
// A result is loaded into the output register in the cycle after its transfer in.
// Throughput: one item per cycle while results are taken; the only limit is the single output register,
//   which is refilled in the same cycle it is taken.
// Reset (rst_n low, synchronous): phase idle, last status idle, thresholds 10 and 100,
//   output register empty. Reset takes effect at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module positioning_move_supervisor_top (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  psup_pkg::in_item_t                        in_data,
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output psup_pkg::out_item_t                       out_data,
  input  wire                                       cfg_we,
  input  wire  [psup_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire  [psup_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
  import psup_pkg::*;

  sup_state_t st_r;
  sup_state_t st_nxt;
  cfg_t       cfg_r;
  out_item_t  out_r;
  out_item_t  res;
  logic       out_valid_r;
  logic       in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  psup_eval u_eval (
    .item (in_data),
    .cur  (st_r),
    .cfg  (cfg_r),
    .nxt  (st_nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.still_threshold <= THR_RESET;
      cfg_r.overrun_limit   <= OVR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STILL_THR: cfg_r.still_threshold <= cfg_wdata[THR_BITS-1:0];
        CFG_OVERRUN:   cfg_r.overrun_limit   <= cfg_wdata[OVR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Position history is payload: written before it is ever read.
      st_r.phase              <= PH_IDLE;
      st_r.target_code        <= '0;
      st_r.dir_decreasing     <= 1'b0;
      st_r.stop_ignored_count <= 2'd0;
      st_r.settle_count       <= 2'd0;
      st_r.last_status        <= ST_IDLE;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= res;
    end
  end

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item did not load the result register");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.kind == KIND_START
      |=> st_r.phase == PH_FIRST && out_r.status == ST_MOVING && !out_r.finished)
    else $error("start item did not arm a new move");

  a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res.finished |=> st_r.phase == PH_IDLE)
    else $error("finished result left the move active");

  a_active_status: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != PH_IDLE |-> st_r.last_status == ST_MOVING ||
                              st_r.last_status == ST_SETTLING)
    else $error("active move holds a final status");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

`default_nettype wire

// File: sim/positioning_move_supervisor_top_tb.sv
// Self-checking testbench for the positioning move supervisor: directed moves, then random traffic.
`timescale 1ns / 1ps

module positioning_move_supervisor_top_tb;
  import psup_pkg::*;

  // Sample status bits, packed as {stop, right, left, limit right, limit left, blocked}
  localparam logic [5:0] B_STOP  = 6'b100000;
  localparam logic [5:0] B_RIGHT = 6'b010000;
  localparam logic [5:0] B_LEFT  = 6'b001000;
  localparam logic [5:0] B_LIM_R = 6'b000100;
  localparam logic [5:0] B_LIM_L = 6'b000010;
  localparam logic [5:0] B_BLOCK = 6'b000001;

  localparam logic DIR_INC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  localparam int SETTLE_POLLS = 3;
  localparam int IN_W = $bits(in_item_t);

  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the supervisor state and its settings
  phase_t mv_phase;
  logic signed [31:0] mv_target;
  logic mv_dec;
  longint mv_prev;
  longint mv_ref;
  logic [1:0] mv_stop_polls;
  logic [1:0] mv_settle;
  status_t mv_last;
  logic [THR_BITS-1:0] cfg_still;
  logic [OVR_BITS-1:0] cfg_overrun;

  out_item_t pending_reports[$];
  int mismatches = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  positioning_move_supervisor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic status_t end_move(input status_t code);
    mv_last = code;
    mv_phase = PH_IDLE;
    return code;
  endfunction

  function automatic status_t judge_motion(input in_item_t it);
    longint p, d, to_go, thr, lim;
    logic stop, drv, lmt;
    p = longint'($signed(it.position));
    stop = it.stop_request;
    drv = it.driving_right | it.driving_left;
    lmt = it.limit_right | it.limit_left | it.blocked;
    thr = longint'(cfg_still);
    lim = longint'(cfg_overrun);
    // Drive off with a stop request ends the move checks right away
    if (stop && !drv) begin
      mv_phase = PH_SETTLE;
      mv_settle = 2'd0;
      mv_last = ST_SETTLING;
      return ST_SETTLING;
    end
    if (mv_phase == PH_MOVING) begin
      d = p - mv_prev;
      if ((d < 0 ? -d : d) <= thr) return end_move(ST_NO_MOTION);
      if ((d < 0) != mv_dec) return end_move(ST_WRONG_DIR);
    end
    if (!stop && !drv) return end_move(ST_DRIVE_DROPPED);
    if (stop && drv) begin
      if (mv_stop_polls > STOP_IGN_MAX) return end_move(ST_STOP_IGNORED);
      mv_stop_polls++;
    end
    if (lmt) return end_move(ST_LIMIT);
    // Only travel past the target on the commanded side counts as overrun
    to_go = longint'(mv_target) - p;
    if (to_go < -lim) begin
      if (!mv_dec) return end_move(ST_OVERRUN);
    end else if (to_go > lim) begin
      if (mv_dec) return end_move(ST_OVERRUN);
    end
    mv_prev = p;
    mv_phase = PH_MOVING;
    mv_last = ST_MOVING;
    return ST_MOVING;
  endfunction

  function automatic status_t judge_settle(input in_item_t it);
    longint p, d;
    p = longint'($signed(it.position));
    if (mv_settle == 2'd0) begin
      mv_ref = p;
      mv_settle = 2'd1;
      return ST_SETTLING;
    end
    d = p - mv_ref;
    if ((d < 0 ? -d : d) > longint'(cfg_still)) return end_move(ST_DRIFT);
    mv_settle++;
    if (mv_settle >= SETTLE_POLLS) return end_move(ST_OK);
    return ST_SETTLING;
  endfunction

  function automatic out_item_t supervise(input in_item_t it);
    out_item_t r;
    r.finished = 1'b0;
    if (it.kind == KIND_START) begin
      mv_target = it.target_position;
      mv_dec = it.move_direction;
      mv_stop_polls = 2'd0;
      mv_settle = 2'd0;
      mv_phase = PH_FIRST;
      mv_last = ST_MOVING;
      r.status = ST_MOVING;
    end else begin
      case (mv_phase)
        PH_FIRST, PH_MOVING: begin
          r.status = judge_motion(it);
          r.finished = (mv_phase == PH_IDLE);
        end
        PH_SETTLE: begin
          r.status = judge_settle(it);
          r.finished = (mv_phase == PH_IDLE);
        end
        default: begin
          r.status = mv_last;
          r.finished = (mv_last != ST_IDLE);
        end
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t random_item();
    return in_item_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
  endfunction

  function automatic in_item_t start_of(input logic [31:0] tgt, input logic dec);
    in_item_t it;
    it = random_item();
    it.kind = KIND_START;
    it.target_position = tgt;
    it.move_direction = dec;
    return it;
  endfunction

  function automatic in_item_t sample_of(input logic [31:0] pos, input logic [5:0] bits);
    in_item_t it;
    it = random_item();
    it.kind = KIND_SAMPLE;
    it.position = pos;
    {it.stop_request, it.driving_right, it.driving_left,
     it.limit_right, it.limit_left, it.blocked} = bits;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(supervise(it));
    items_sent++;
  endtask

  // Hold the input and wait for every outstanding report
  task automatic settle_traffic();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_STILL_THR: cfg_still = val[THR_BITS-1:0];
      CFG_OVERRUN:   cfg_overrun = val[OVR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic test_idle_sample();
    send_item(sample_of($urandom(), 6'($urandom())));
  endtask

  task automatic test_clean_move();
    send_item(start_of(32'd1000, DIR_INC));
    send_item(sample_of(32'd0, B_LEFT));
    send_item(sample_of(32'd990, B_STOP));
    send_item(sample_of(32'd992, 6'($urandom())));
    send_item(sample_of(32'd995, 6'($urandom())));
    send_item(sample_of(32'd998, 6'($urandom())));
    // Idle sample repeats the final status
    send_item(sample_of($urandom(), 6'($urandom())));
  endtask

  task automatic test_no_motion();
    send_item(start_of(32'd5000, DIR_INC));
    send_item(sample_of(32'd100, B_LEFT));
    send_item(sample_of(32'd105, B_LEFT));
  endtask

  task automatic test_wrong_direction();
    send_item(start_of(COORD_MIN, DIR_DEC));
    send_item(sample_of(COORD_MIN, B_RIGHT));
    send_item(sample_of(COORD_MAX, B_RIGHT));
  endtask

  task automatic test_drive_dropped();
    send_item(start_of(32'd0, DIR_INC));
    send_item(sample_of(32'd0, 6'b0));
  endtask

  task automatic test_stop_ignored();
    send_item(start_of(32'd10000, DIR_INC));
    send_item(sample_of(32'd0, B_STOP | B_LEFT));
    send_item(sample_of(32'd100, B_STOP | B_LEFT));
    send_item(sample_of(32'd200, B_STOP | B_LEFT));
  endtask

  task automatic test_limits();
    send_item(start_of(32'd1000, DIR_INC));
    send_item(sample_of(32'd0, B_LEFT | B_LIM_R));
    send_item(start_of(32'd1000, DIR_INC));
    send_item(sample_of(32'd0, B_LEFT | B_LIM_L));
    send_item(start_of(-32'sd1000, DIR_DEC));
    send_item(sample_of(32'd0, B_RIGHT | B_BLOCK));
  endtask

  task automatic test_overrun();
    // Far short of the target is no error; the restart below drops that move
    send_item(start_of(COORD_MAX, DIR_INC));
    send_item(sample_of(32'd0, B_LEFT));
    send_item(start_of(32'd0, DIR_INC));
    send_item(sample_of(32'd100, B_LEFT));
    send_item(sample_of(32'd201, B_LEFT));
    send_item(start_of(32'd0, DIR_DEC));
    send_item(sample_of(-32'sd101, B_RIGHT));
  endtask

  task automatic test_drift();
    send_item(start_of(32'd0, DIR_INC));
    send_item(sample_of(32'd50, B_STOP | B_LIM_L));
    send_item(sample_of(32'd60, 6'($urandom())));
    send_item(sample_of(32'd71, 6'($urandom())));
  endtask

  // One plausible move with random content, occasionally broken
  task automatic run_random_move();
    longint pos, thr, anchor, tgt;
    int sgn, polls, k, pick;
    logic dec;
    logic [5:0] drive, bits;
    thr = longint'(cfg_still);
    dec = 1'($urandom_range(1));
    sgn = dec ? -1 : 1;
    drive = dec ? B_RIGHT : B_LEFT;
    pos = longint'($urandom_range(2000000000)) - 64'sd1000000000;
    polls = $urandom_range(1, 8);
    tgt = pos + sgn * polls * (thr + 150) + longint'($urandom_range(400)) - 200;
    send_item(start_of(32'(tgt), dec));
    for (k = 0; k < polls; k++) begin
      pick = $urandom_range(99);
      if (pick < 3) pos += longint'($urandom_range(32'(2 * thr))) - thr;
      else if (pick < 6) pos -= sgn * (thr + 1 + longint'($urandom_range(300)));
      else pos += sgn * (thr + 1 + longint'($urandom_range(300)));
      if (pick >= 17) bits = drive;
      else if (pick >= 15) bits = B_RIGHT | B_LEFT;
      else if (pick >= 12) bits = drive | (B_LIM_R >> $urandom_range(2));
      else if (pick >= 8) bits = drive | B_STOP;
      else if (pick >= 6) bits = 6'b0;
      else bits = drive;
      send_item(sample_of(32'(pos), bits));
      if (mv_phase == PH_IDLE) return;
    end
    // Abandon the move now and then; the next start restarts it
    if ($urandom_range(19) == 0) return;
    send_item(sample_of(32'(pos), B_STOP | 6'($urandom_range(7))));
    anchor = pos + longint'($urandom_range(32'(2 * thr))) - thr;
    for (k = 0; k < SETTLE_POLLS; k++) begin
      if (k == 0) pos = anchor;
      else if ($urandom_range(14) == 0)
        pos = anchor + sgn * (thr + 1 + longint'($urandom_range(100)));
      else pos = anchor + longint'($urandom_range(32'(2 * thr))) - thr;
      send_item(sample_of(32'(pos), 6'($urandom())));
      if (mv_phase == PH_IDLE) break;
    end
    if ($urandom_range(9) == 0) send_item(sample_of($urandom(), 6'($urandom())));
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct,
                                     input logic [THR_BITS-1:0] thr,
                                     input logic [OVR_BITS-1:0] ovr);
    int stop_at;
    in_item_t junk;
    settle_traffic();
    write_cfg(CFG_STILL_THR, CFG_DATA_W'(thr));
    write_cfg(CFG_OVERRUN, ovr);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        junk = random_item();
        send_item(junk);
      end else begin
        run_random_move();
      end
    end
  endtask

  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%t unexpected report: status %0d finished %0b",
                 $realtime, out_data.status, out_data.finished);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data.status !== want.status) begin
          $display("%t status: expected %0d, got %0d", $realtime, want.status, out_data.status);
          mismatches++;
        end
        if (out_data.finished !== want.finished) begin
          $display("%t finished: expected %0b, got %0b",
                   $realtime, want.finished, out_data.finished);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_STILL_THR;
    cfg_wdata = '0;
    mv_phase = PH_IDLE;
    mv_target = '0;
    mv_dec = 1'b0;
    mv_prev = 0;
    mv_ref = 0;
    mv_stop_polls = 2'd0;
    mv_settle = 2'd0;
    mv_last = ST_IDLE;
    cfg_still = THR_RESET;
    cfg_overrun = OVR_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_sample();
    test_clean_move();
    test_no_motion();
    test_wrong_direction();
    test_drive_dropped();
    test_stop_ignored();
    test_limits();
    test_overrun();
    test_drift();

    test_random_traffic(375, 0, 0, 16'd10, 24'd100);
    test_random_traffic(375, 86, 0, 16'd0, 24'd0);
    test_random_traffic(375, 0, 86, 16'hffff, 24'hffffff);
    test_random_traffic(375, 25, 25, 16'($urandom_range(300)), 24'($urandom_range(5000)));

    settle_traffic();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
rtl/psup_pkg.sv
rtl/psup_eval.sv
rtl/positioning_move_supervisor_top.sv
sim/positioning_move_supervisor_top_tb.sv
